// ===== hw/rtl/max_pixel_color_distance_assert.svh =====
// Assertion macros for the checker module of the pixel distance block.
`ifndef MAX_PIXEL_COLOR_DISTANCE_ASSERT_SVH
`define MAX_PIXEL_COLOR_DISTANCE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MPCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpcd assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MPCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpcd assertion failed");

`endif

// ===== hw/rtl/mpcd_pkg.sv =====
// Shared types, constants and helper functions of the pixel distance block.
`timescale 1ns / 1ps

package mpcd_pkg;

    localparam int MPCD_FRACTION_BITS = 8;
    localparam int MAX_SQ_W           = 18;
    localparam int DIST_W             = 17;
    localparam int CH_W               = 8;
    localparam int PROD_W             = 2 * CH_W;

    localparam int PADDR_W            = 3;
    localparam logic [PADDR_W-1:0] ADDR_CHANNEL_MODE = 3'd0;

    localparam logic [1:0] MODE_GREY  = 2'd0;
    localparam logic [1:0] MODE_RGB   = 2'd1;
    localparam logic [1:0] MODE_ALPHA = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
    } mul_req_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CALC   = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_ROOT   = 5'b01000,
        ST_EMIT   = 5'b10000
    } mpcd_state_t;

    function automatic logic [CH_W-1:0] chan_delta(input logic [CH_W-1:0] x,
                                                   input logic [CH_W-1:0] y);
        chan_delta = (x >= y) ? (x - y) : (y - x);
    endfunction

    // floor(x / 255), exact for x up to 255*255
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + {{(CH_W+1){1'b0}}, x[PROD_W-1:CH_W]} + {{PROD_W{1'b0}}, 1'b1};
        div255 = t[PROD_W-1:CH_W];
    endfunction

endpackage

// ===== hw/rtl/mpcd_mul.sv =====
// Shared 8x8 multiplier with a registered product.
`timescale 1ns / 1ps

module mpcd_mul
    import mpcd_pkg::*;
(
    input  logic              clk,
    input  mul_req_t          req,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = req.a * req.b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/mpcd_isqrt.sv =====
// Bit-serial integer square root of (value << 2*FRACTION_BITS), one root bit a cycle.
`timescale 1ns / 1ps

module mpcd_isqrt
    import mpcd_pkg::*;
#(
    parameter int FRACTION_BITS = MPCD_FRACTION_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MAX_SQ_W-1:0] value,
    output logic                done,
    output logic [MAX_SQ_W/2+FRACTION_BITS-1:0] root
);

    localparam int OPND_W = MAX_SQ_W + 2 * FRACTION_BITS;
    localparam int ROOT_W = OPND_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [OPND_W-1:0] opnd_reg, opnd_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;

    assign rem_sh = {rem_reg[REM_W-3:0], opnd_reg[OPND_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_comb
    begin
        opnd_next = opnd_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            opnd_next = OPND_W'(value) << (2 * FRACTION_BITS);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            opnd_next = opnd_reg << 2;
            rem_next  = fits ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[ROOT_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hw/rtl/max_pixel_color_distance.sv =====
// Top level: largest squared color distance over an image pair, and its root.
// Usage:
//  - Slave stream carries one pixel pair per request, tlast on the final pair.
//  - Master stream gives one result per image: max squared distance and its
//    square root in unsigned fixed point with FRACTION_BITS fraction bits.
//  - APB register 0 (addr 0) is channel_mode; write it only while idle.
//  - Each pair runs through one shared 8x8 multiplier under a step counter:
//    grey mode 1 product, RGB 3, alpha mode 7 (3 weights then 4 squares),
//    each product landing in the cycle after issue. s_tready is low
//    meanwhile, so a new pair is taken only once the last one is done.
//  - On the last pair the bit-serial root unit runs and then the output
//    register is loaded: the result shows as the input side reopens.
//  - Output register frees the input side: a pending result does not block
//    new pairs; only a following last pair waits for the receiver.
//  - Reset: channel_mode = 2, running maximum 0, no result pending.
`timescale 1ns / 1ps

module max_pixel_color_distance
    import mpcd_pkg::*;
#(
    parameter int FRACTION_BITS = MPCD_FRACTION_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // pixel pair stream
    input  logic               s_tvalid,
    output logic               s_tready,
    // first_blue, first_green, first_red, first_alpha,
    // second_blue, second_green, second_red, second_alpha (8 bits each)
    input  logic [63:0]        s_tdata,
    input  logic               s_tlast,   // last_pixel
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    // max_square_distance [17:0], max_distance_q8 [34:18], zero pad [39:35]
    output logic [39:0]        m_tdata
);

    localparam int ROOT_W = MAX_SQ_W / 2 + FRACTION_BITS;

    // configuration
    logic [1:0] channel_mode_reg, channel_mode_next;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[PADDR_W-1:2] == ADDR_CHANNEL_MODE[PADDR_W-1:2]) ?
                    {30'd0, channel_mode_reg} : 32'd0;

    always_comb
    begin
        channel_mode_next = channel_mode_reg;
        if (cfg_wr && (paddr[PADDR_W-1:2] == ADDR_CHANNEL_MODE[PADDR_W-1:2]))
            channel_mode_next = pwdata[1:0];
    end

    // datapath state
    mpcd_state_t state_reg, state_next;
    logic [2:0]          step_reg, step_next;
    logic [CH_W-1:0]     db_reg, dg_reg, dr_reg, da_reg, am_reg;
    logic [CH_W-1:0]     db_next, dg_next, dr_next, da_next, am_next;
    logic [CH_W-1:0]     wb_reg, wg_reg, wr_reg, wb_next, wg_next, wr_next;
    logic                last_reg, last_next;
    logic [MAX_SQ_W-1:0] acc_reg, acc_next;
    logic [MAX_SQ_W-1:0] max_reg, max_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [MAX_SQ_W-1:0] out_sq_reg, out_sq_next;
    logic [DIST_W-1:0]   out_dist_reg, out_dist_next;

    logic                four_ch;
    logic [2:0]          last_op;
    logic [2:0]          prev_op;
    mul_req_t            mul_req;
    logic [PROD_W-1:0]   prod;
    logic [MAX_SQ_W-1:0] new_max;
    logic                root_start;
    logic                root_done;
    logic [ROOT_W-1:0]   root;
    logic [ROOT_W+DIST_W-1:0] root_ext;
    logic                s_acc;

    assign four_ch  = channel_mode_reg[1];
    assign prev_op  = step_reg - 3'd1;
    assign new_max  = (acc_reg > max_reg) ? acc_reg : max_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign root_start = (state_reg == ST_UPDATE) && last_reg;
    assign root_ext = {{DIST_W{1'b0}}, root};

    always_comb
    begin
        case (channel_mode_reg)
            MODE_GREY: last_op = 3'd0;
            MODE_RGB:  last_op = 3'd2;
            default:   last_op = 3'd6;
        endcase
    end

    // operand schedule: alpha mode weights b, g, r, then squares da, wb, wg, wr; otherwise squares db, dg, dr in turn
    always_comb
    begin
        mul_req.a = db_reg;
        mul_req.b = db_reg;
        if (four_ch)
        begin
            case (step_reg)
                3'd0:    begin mul_req.a = db_reg; mul_req.b = am_reg; end
                3'd1:    begin mul_req.a = dg_reg; mul_req.b = am_reg; end
                3'd2:    begin mul_req.a = dr_reg; mul_req.b = am_reg; end
                3'd3:    begin mul_req.a = da_reg; mul_req.b = da_reg; end
                3'd4:    begin mul_req.a = wb_reg; mul_req.b = wb_reg; end
                3'd5:    begin mul_req.a = wg_reg; mul_req.b = wg_reg; end
                default: begin mul_req.a = wr_reg; mul_req.b = wr_reg; end
            endcase
        end
        else
        begin
            case (step_reg)
                3'd1:    begin mul_req.a = dg_reg; mul_req.b = dg_reg; end
                3'd2:    begin mul_req.a = dr_reg; mul_req.b = dr_reg; end
                default: begin mul_req.a = db_reg; mul_req.b = db_reg; end
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        db_next       = db_reg;
        dg_next       = dg_reg;
        dr_next       = dr_reg;
        da_next       = da_reg;
        am_next       = am_reg;
        wb_next       = wb_reg;
        wg_next       = wg_reg;
        wr_next       = wr_reg;
        last_next     = last_reg;
        acc_next      = acc_reg;
        max_next      = max_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_sq_next   = out_sq_reg;
        out_dist_next = out_dist_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    db_next   = chan_delta(s_tdata[7:0],   s_tdata[39:32]);
                    dg_next   = chan_delta(s_tdata[15:8],  s_tdata[47:40]);
                    dr_next   = chan_delta(s_tdata[23:16], s_tdata[55:48]);
                    da_next   = chan_delta(s_tdata[31:24], s_tdata[63:56]);
                    am_next   = (s_tdata[31:24] > s_tdata[63:56]) ?
                                s_tdata[31:24] : s_tdata[63:56];
                    last_next = s_tlast;
                    acc_next  = '0;
                    step_next = 3'd0;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg != 3'd0)
                begin
                    // product of the op issued last cycle
                    if (four_ch && (prev_op < 3'd3))
                    begin
                        case (prev_op)
                            3'd0:    wb_next = div255(prod);
                            3'd1:    wg_next = div255(prod);
                            default: wr_next = div255(prod);
                        endcase
                    end
                    else
                        acc_next = acc_reg + {{(MAX_SQ_W-PROD_W){1'b0}}, prod};
                    if (prev_op == last_op)
                        state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                max_next   = new_max;
                state_next = last_reg ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT:
            begin
                if (root_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_sq_next   = max_reg;
                    out_dist_next = root_ext[DIST_W-1:0];
                    max_next      = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            channel_mode_reg <= MODE_ALPHA;
            max_reg          <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            channel_mode_reg <= channel_mode_next;
            max_reg          <= max_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        db_reg       <= db_next;
        dg_reg       <= dg_next;
        dr_reg       <= dr_next;
        da_reg       <= da_next;
        am_reg       <= am_next;
        wb_reg       <= wb_next;
        wg_reg       <= wg_next;
        wr_reg       <= wr_next;
        last_reg     <= last_next;
        acc_reg      <= acc_next;
        out_sq_reg   <= out_sq_next;
        out_dist_reg <= out_dist_next;
    end

    mpcd_mul u_mul
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    mpcd_isqrt #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (new_max),
        .done  (root_done),
        .root  (root)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_dist_reg, out_sq_reg};

endmodule

// ===== hw/rtl/mpcd_checker.sv =====
// Port-level checker for the pixel distance block, bound to the top level.
`timescale 1ns / 1ps
`include "max_pixel_color_distance_assert.svh"

module mpcd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // stalled result holds
    `MPCD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // block drops s_tready after taking a pair
    `MPCD_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)
    // squared distance never exceeds four full-scale terms
    `MPCD_ASSERT_NOW(a_sq_range, m_tvalid, m_tdata[17:0] <= 18'd260100)
    // pad bits stay zero
    `MPCD_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[39:35] == 5'd0)

endmodule

bind max_pixel_color_distance mpcd_checker u_mpcd_checker (.*);
